// ----- rtl/teq_pkg.sv -----
// Shared types and constants of the timer expiry queue.
package teq_pkg;

	localparam int MaxResults = 64;
	localparam logic [31:0] MaxTime = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_ADD_WR,
		ST_TK_RD,
		ST_TK_CMP,
		ST_TK_END
	} state_t;

	typedef struct packed {
		logic [31:0] expiry;
		logic [7:0]  id;
	} entry_t;

	typedef struct packed {
		logic [7:0] fired_id;
		logic       fired;
		logic       last;
		logic       status;
	} res_t;

endpackage

// ----- rtl/teq_mem.sv -----
// Entry memory: one write port, one registered read port.
module teq_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  teq_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output teq_pkg::entry_t rd_data
);
	import teq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/teq_ctrl.sv -----
// Sequencer: sorted circular queue kept in the entry memory.
module teq_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      req_type,
	input  logic [31:0]     now_time,
	input  logic [15:0]     delay_seconds,
	input  logic [7:0]      task_id,
	input  logic            out_ok,
	output logic            emit,
	output teq_pkg::res_t   emit_res,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output teq_pkg::entry_t wr_data,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	input  teq_pkg::entry_t rd_data
);
	import teq_pkg::*;

	state_t      st_q, st_d;
	logic [31:0] now_q, exp_q;
	logic [7:0]  id_q, pendid_q;
	logic        pend_q;
	logic [CW-1:0] pos_q, n_q, count_q;
	logic [AW-1:0] head_q;
	logic        ld_req, pos_dec, n_inc, take_pend, add_done, tick_done, clr;
	logic [32:0] sum;
	logic [31:0] exp_new;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [AW+1:0] t;
		t = (AW+2)'(h) + (AW+2)'(off);
		if (t >= (AW+2)'(DEPTH)) begin
			t = t - (AW+2)'(DEPTH);
		end
		return t[AW-1:0];
	endfunction

	assign sum = {1'b0, now_time} + {17'b0, delay_seconds};
	assign exp_new = sum[32] ? MaxTime : sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			head_q <= '0;
			pend_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr) begin
				count_q <= '0;
			end else if (add_done) begin
				count_q <= count_q + 1'b1;
			end else if (tick_done) begin
				count_q <= count_q - n_q;
			end
			if (tick_done) begin
				head_q <= phys(head_q, n_q);
				pend_q <= 1'b0;
			end else if (take_pend) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_req) begin
			now_q <= now_time;
			exp_q <= exp_new;
			id_q <= task_id;
			pos_q <= count_q;
			n_q <= '0;
		end else begin
			if (pos_dec) begin
				pos_q <= pos_q - 1'b1;
			end
			if (n_inc) begin
				n_q <= n_q + 1'b1;
			end
		end
		if (take_pend) begin
			pendid_q <= rd_data.id;
		end
	end

	always_comb begin
		st_d = st_q;
		in_ready = 1'b0;
		emit = 1'b0;
		emit_res = '0;
		emit_res.last = 1'b1;
		wr_en = 1'b0;
		wr_addr = phys(head_q, pos_q);
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = phys(head_q, n_q);
		ld_req = 1'b0;
		pos_dec = 1'b0;
		n_inc = 1'b0;
		take_pend = 1'b0;
		add_done = 1'b0;
		tick_done = 1'b0;
		clr = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = out_ok;
				if (in_valid && out_ok) begin
					ld_req = 1'b1;
					case (req_t'(req_type))
						REQ_ADD: begin
							emit = 1'b1;
							if (count_q >= CW'(DEPTH)) begin
								emit_res.status = 1'b1;
							end else if (count_q == '0) begin
								st_d = ST_ADD_WR;
							end else begin
								st_d = ST_ADD_RD;
							end
						end
						REQ_TICK: st_d = ST_TK_RD;
						REQ_CLEAR: begin
							emit = 1'b1;
							clr = 1'b1;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			ST_ADD_RD: begin
				rd_en = 1'b1;
				rd_addr = phys(head_q, pos_q - 1'b1);
				st_d = ST_ADD_CMP;
			end
			ST_ADD_CMP: begin
				if (rd_data.expiry > exp_q) begin
					wr_en = 1'b1;
					pos_dec = 1'b1;
					st_d = (pos_q == CW'(1)) ? ST_ADD_WR : ST_ADD_RD;
				end else begin
					st_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				wr_en = 1'b1;
				wr_data.expiry = exp_q;
				wr_data.id = id_q;
				add_done = 1'b1;
				st_d = ST_IDLE;
			end
			ST_TK_RD: begin
				if (n_q < count_q && n_q < MaxResults) begin
					rd_en = 1'b1;
					st_d = ST_TK_CMP;
				end else begin
					st_d = ST_TK_END;
				end
			end
			ST_TK_CMP: begin
				if (rd_data.expiry <= now_q) begin
					if (!pend_q || out_ok) begin
						emit = pend_q;
						emit_res.fired = 1'b1;
						emit_res.last = 1'b0;
						emit_res.fired_id = pendid_q;
						take_pend = 1'b1;
						n_inc = 1'b1;
						st_d = ST_TK_RD;
					end
				end else begin
					st_d = ST_TK_END;
				end
			end
			ST_TK_END: begin
				if (out_ok) begin
					emit = 1'b1;
					emit_res.fired = pend_q;
					emit_res.fired_id = pend_q ? pendid_q : 8'd0;
					tick_done = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("entry count above depth");
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_ok) else $error("result emitted into busy output");
	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_done |-> (n_q <= count_q)) else $error("tick removes too many");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q != ST_ADD_CMP && st_q != ST_TK_CMP))
		else $error("request started mid-operation");

endmodule

// ----- rtl/timer_expiry_priority_queue_unit.sv -----
// Top level of the timer expiry queue with its output register.
// Add, clear and unused requests give their word in the cycle after acceptance.
// Add reads stored entries from the tail, moves each that expires later up one slot, then writes the new entry.
// Tick reads entries from the head, one memory read per step, and gives a word per expired timer (one word if none).
// One request at a time; the output register holds a word while the next work goes on.
// Reset (arst_n low, asynchronous) empties the queue; memory contents are not cleared.
module timer_expiry_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // now_time[31:0], delay_seconds[47:32], task_id[55:48]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // fired_id[7:0]
	output logic [1:0]  m_tuser,  // fired[0], status[1]
	output logic        m_tlast
);
	import teq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic    out_ok, emit, wr_en, rd_en, valid_q;
	res_t    emit_res, res_q;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t  wr_data, rd_data;

	assign out_ok = !valid_q || m_tready;

	teq_ctrl #(.DEPTH(QUEUE_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.req_type(s_tuser), .now_time(s_tdata[31:0]),
		.delay_seconds(s_tdata[47:32]), .task_id(s_tdata[55:48]),
		.out_ok(out_ok), .emit(emit), .emit_res(emit_res),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	teq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ok) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_ok) begin
			res_q <= emit_res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = res_q.fired_id;
	assign m_tuser = {res_q.status, res_q.fired};
	assign m_tlast = res_q.last;

endmodule
